>>> rtl/fsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared constants, opcodes, status codes, item types and the decoder of the
// stack machine core.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int WORD_BITS    = 64;
  localparam int CODE_BITS    = 16;
  localparam int DATA_DEPTH   = 32;
  localparam int RETURN_DEPTH = 32;
  localparam int DS_AW        = $clog2(DATA_DEPTH);
  localparam int RS_AW        = $clog2(RETURN_DEPTH);
  localparam int CNT_W        = 6;
  localparam int OP_W         = 6;
  localparam int OFF_W        = 24;
  localparam int LANE_BITS    = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD   = 6'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 6'd1;
  localparam logic [OP_W-1:0] OP_LSL   = 6'd2;
  localparam logic [OP_W-1:0] OP_LSR   = 6'd3;
  localparam logic [OP_W-1:0] OP_2SWAP = 6'd4;
  localparam logic [OP_W-1:0] OP_SWAP  = 6'd5;
  localparam logic [OP_W-1:0] OP_DROP  = 6'd6;
  localparam logic [OP_W-1:0] OP_2OVER = 6'd7;
  localparam logic [OP_W-1:0] OP_OVER  = 6'd8;
  localparam logic [OP_W-1:0] OP_DUP   = 6'd9;
  localparam logic [OP_W-1:0] OP_ROT   = 6'd10;
  localparam logic [OP_W-1:0] OP_NROT  = 6'd11;
  localparam logic [OP_W-1:0] OP_TA    = 6'd12;
  localparam logic [OP_W-1:0] OP_FA    = 6'd13;
  localparam logic [OP_W-1:0] OP_TB    = 6'd14;
  localparam logic [OP_W-1:0] OP_FB    = 6'd15;
  localparam logic [OP_W-1:0] OP_TR    = 6'd16;
  localparam logic [OP_W-1:0] OP_FR    = 6'd17;
  localparam logic [OP_W-1:0] OP_ZERO  = 6'd18;
  localparam logic [OP_W-1:0] OP_IMM8  = 6'd19;
  localparam logic [OP_W-1:0] OP_IMMW  = 6'd20;
  localparam logic [OP_W-1:0] OP_2LD   = 6'd21;
  localparam logic [OP_W-1:0] OP_LD    = 6'd22;
  localparam logic [OP_W-1:0] OP_BLD   = 6'd23;
  localparam logic [OP_W-1:0] OP_2ST   = 6'd24;
  localparam logic [OP_W-1:0] OP_ST    = 6'd25;
  localparam logic [OP_W-1:0] OP_BST   = 6'd26;
  localparam logic [OP_W-1:0] OP_GT    = 6'd27;
  localparam logic [OP_W-1:0] OP_LT    = 6'd28;
  localparam logic [OP_W-1:0] OP_EQ    = 6'd29;
  localparam logic [OP_W-1:0] OP_NE    = 6'd30;
  localparam logic [OP_W-1:0] OP_AND   = 6'd31;
  localparam logic [OP_W-1:0] OP_OR    = 6'd32;
  localparam logic [OP_W-1:0] OP_XOR   = 6'd33;
  localparam logic [OP_W-1:0] OP_NOT   = 6'd34;
  localparam logic [OP_W-1:0] OP_BGT   = 6'd35;
  localparam logic [OP_W-1:0] OP_BLT   = 6'd36;
  localparam logic [OP_W-1:0] OP_BZ    = 6'd37;
  localparam logic [OP_W-1:0] OP_BNZ   = 6'd38;
  localparam logic [OP_W-1:0] OP_B     = 6'd39;
  localparam logic [OP_W-1:0] OP_BL    = 6'd40;
  localparam logic [OP_W-1:0] OP_BNL   = 6'd41;
  localparam logic [OP_W-1:0] OP_RET   = 6'd42;

  // run status
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  // classified instruction as queued between front and back
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [WORD_BITS-1:0] imm;
    logic [OFF_W-1:0]     off;
    logic                 bad;     // undefined opcode
    logic [1:0]           need_d;  // data entries below top that must exist
    logic [1:0]           room_d;  // free data entries needed
    logic                 need_r;  // return entries that must exist
    logic                 room_r;  // free return entries needed
    logic [1:0]           nrd;     // stack/memory read steps
  } dec_t;

  // result of one instruction
  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_W-1:0]     depth;
    logic [WORD_BITS-1:0] top;
    logic [CODE_BITS-1:0] pc;
  } res_t;

  function automatic dec_t decode(input logic [OP_W-1:0] op,
                                  input logic [WORD_BITS-1:0] imm,
                                  input logic [OFF_W-1:0] off);
    dec_t d;
    d = '0;
    d.op  = op;
    d.imm = imm;
    d.off = off;
    case (op)
      OP_ADD, OP_SUB, OP_LSL, OP_LSR, OP_SWAP, OP_DROP, OP_TA, OP_TB,
      OP_GT, OP_LT, OP_EQ, OP_NE, OP_AND, OP_OR, OP_XOR,
      OP_BGT, OP_BLT, OP_BZ, OP_BNZ: begin
        d.need_d = 2'd1;
        d.nrd    = 2'd1;
      end
      OP_OVER: begin
        d.need_d = 2'd1;
        d.room_d = 2'd1;
        d.nrd    = 2'd1;
      end
      OP_TR: begin
        d.need_d = 2'd1;
        d.room_r = 1'b1;
        d.nrd    = 2'd1;
      end
      OP_2SWAP, OP_2ST: begin
        d.need_d = 2'd3;
        d.nrd    = 2'd3;
      end
      OP_2OVER: begin
        d.need_d = 2'd3;
        d.room_d = 2'd2;
        d.nrd    = 2'd3;
      end
      OP_ROT, OP_NROT, OP_ST, OP_BST: begin
        d.need_d = 2'd2;
        d.nrd    = 2'd2;
      end
      OP_DUP, OP_FA, OP_FB, OP_ZERO, OP_IMM8, OP_IMMW: begin
        d.room_d = 2'd1;
      end
      OP_FR: begin
        d.room_d = 2'd1;
        d.need_r = 1'b1;
        d.nrd    = 2'd1;
      end
      OP_2LD: begin
        d.room_d = 2'd1;
        d.nrd    = 2'd2;
      end
      OP_LD, OP_BLD, OP_RET: begin
        d.nrd = 2'd1;
      end
      OP_BL: begin
        d.room_r = 1'b1;
      end
      OP_NOT, OP_B, OP_BNL: begin
        d.nrd = 2'd0;
      end
      default: begin
        d.bad = 1'b1;
      end
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

>>> rtl/forth_stack_machine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// forth_stack_machine_core
// Stack machine core executing one decoded instruction per input transfer.
// ----------------------------------------------------------------------------
// Each accepted instruction produces one result transfer with the next fetch
// address, the data stack top, the depth below the top and the run status.
// Instructions queue in a two-entry buffer and run in an execution unit whose
// data stack, return stack and data memory each sit in a single-read,
// single-write RAM, so the cost per instruction is set by how many stack or
// memory words it touches: an instruction with no reads goes straight from
// issue to execute, one with reads adds a step per read step and one capture
// step for the read latency, and one with writes adds a step per write step.
// After reset the data memory is zeroed before the first instruction runs;
// MEM_WORDS must be a power of two. Once the status is no longer running,
// every further instruction returns the same result until reset or a start
// address write. The start address may be written only while idle.
// ----------------------------------------------------------------------------
module forth_stack_machine_core
  import fsc_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,   // start_address
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [5:0]  in_tuser,   // action
  input  wire logic [87:0] in_tdata,   // immediate[63:0], branch_offset[87:64]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata   // next_pc[15:0], top_value[79:16],
                                       // stack_depth[85:80], status[87:86]
);

  logic  q_valid, q_pop;
  dec_t  q_item;
  logic  res_valid, res_ready, res_load, clearing;
  res_t  res;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;

  assign cfg_ready = 1'b1;

  fsc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  fsc_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready), .cfg_value(cfg_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .clearing(clearing)
  );

  // output register
  assign res_ready     = !out_valid_r || out_tready;
  assign res_load      = res_valid && res_ready;
  assign out_valid_nxt = res_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.status, out_res_r.depth, out_res_r.top, out_res_r.pc};

`ifndef ASSERT_OFF
  // no result leaves while the data memory is still being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !res_valid)
    else $error("result offered during memory clear");

  // a result waiting on the output register holds steady
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed");

  // reported depth never exceeds the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res_r.depth <= CNT_W'(DATA_DEPTH)))
    else $error("stack depth out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/fsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/fsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_front
// Input side: accepts instruction transfers, classifies them and holds them
// in a two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
module fsc_front
  import fsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [5:0]  in_tuser,   // action
  input  wire logic [87:0] in_tdata,   // immediate[63:0], branch_offset[87:64]
  output logic             q_valid,
  output dec_t             q_item,
  input  wire logic        q_pop
);

  dec_t       fifo_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wptr_nxt = push  ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= decode(in_tuser, in_tdata[63:0], in_tdata[87:64]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/fsc_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_exec
// Execution unit: sequences stack and memory reads, computes the new machine
// state, writes back to the stacks and data memory, and hands out the result.
// ----------------------------------------------------------------------------
module fsc_exec
  import fsc_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CODE_BITS-1:0] cfg_value,
  input  wire logic                 q_valid,
  input  wire dec_t                 q_item,
  output logic                      q_pop,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res,
  output logic                      clearing
);

  localparam int MEM_AW = $clog2(MEM_WORDS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [MEM_AW-1:0]    clr_r, clr_nxt;
  dec_t                 ins_r, ins_nxt;
  logic [CODE_BITS-1:0] pc_r, pc_nxt;
  logic [WORD_BITS-1:0] tos_r, tos_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] rtop_r, rtop_nxt;
  logic [CNT_W-1:0]     rcnt_r, rcnt_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [1:0]           run_r, run_nxt;

  logic [WORD_BITS-1:0] d_r [3];
  logic [WORD_BITS-1:0] d_nxt [3];
  logic [WORD_BITS-1:0] m_r [2];
  logic [WORD_BITS-1:0] m_nxt [2];
  logic [WORD_BITS-1:0] rr_r, rr_nxt;

  logic [DS_AW-1:0]     wds_addr_r [3];
  logic [DS_AW-1:0]     wds_addr_nxt [3];
  logic [WORD_BITS-1:0] wds_data_r [3];
  logic [WORD_BITS-1:0] wds_data_nxt [3];
  logic [1:0]           wds_n_r, wds_n_nxt;
  logic [MEM_AW-1:0]    wm_addr_r [2];
  logic [MEM_AW-1:0]    wm_addr_nxt [2];
  logic [WORD_BITS-1:0] wm_data_r [2];
  logic [WORD_BITS-1:0] wm_data_nxt [2];
  logic [1:0]           wm_n_r, wm_n_nxt;

  // RAM ports
  logic                 ds_we, rs_we, mem_we;
  logic [DS_AW-1:0]     ds_waddr, ds_raddr;
  logic [RS_AW-1:0]     rs_waddr, rs_raddr;
  logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] ds_wdata, rs_wdata, mem_wdata;
  logic [WORD_BITS-1:0] ds_q, rs_q, mem_q;

  // address helpers
  logic [CNT_W-1:0]     rd_cnt, cm1, cm2, cm3, cp1, rcm1;
  logic [DS_AW-1:0]     ix_m1, ix_m2, ix_m3, ix_p0, ix_p1;
  logic [MEM_AW-1:0]    mi;
  logic [1:0]           cap_ix;
  logic [LANE_BITS+2:0] lane_sh;
  logic [WORD_BITS-1:0] byte_sh, lane_mask, merged;
  logic [CODE_BITS-1:0] pc1, pc2, pc4, pc9, br;
  logic                 fault;

  assign cm1    = cnt_r - CNT_W'(1);
  assign cm2    = cnt_r - CNT_W'(2);
  assign cm3    = cnt_r - CNT_W'(3);
  assign cp1    = cnt_r + CNT_W'(1);
  assign rcm1   = rcnt_r - CNT_W'(1);
  assign ix_m1  = cm1[DS_AW-1:0];
  assign ix_m2  = cm2[DS_AW-1:0];
  assign ix_m3  = cm3[DS_AW-1:0];
  assign ix_p0  = cnt_r[DS_AW-1:0];
  assign ix_p1  = cp1[DS_AW-1:0];
  assign rd_cnt = cm1 - CNT_W'(step_r);
  assign mi     = tos_r[LANE_BITS +: MEM_AW];
  assign cap_ix = step_r - 2'd1;

  assign ds_raddr  = rd_cnt[DS_AW-1:0];
  assign rs_raddr  = rcm1[RS_AW-1:0];
  assign mem_raddr = mi + MEM_AW'(step_r);

  // byte lane helpers
  assign lane_sh   = {tos_r[LANE_BITS-1:0], 3'b000};
  assign byte_sh   = m_r[0] >> lane_sh;
  assign lane_mask = {{(WORD_BITS-8){1'b0}}, 8'hFF} << lane_sh;
  assign merged    = (m_r[0] & ~lane_mask)
                   | ({{(WORD_BITS-8){1'b0}}, d_r[0][7:0]} << lane_sh);

  // code addresses
  assign pc1 = pc_r + CODE_BITS'(1);
  assign pc2 = pc_r + CODE_BITS'(2);
  assign pc4 = pc_r + CODE_BITS'(4);
  assign pc9 = pc_r + CODE_BITS'(9);
  assign br  = pc1 + ins_r.off[CODE_BITS-1:0];

  // stack bounds check for the instruction at the queue head
  assign fault = (cnt_r < CNT_W'(q_item.need_d))
              || ((cnt_r + CNT_W'(q_item.room_d)) > CNT_W'(DATA_DEPTH))
              || (rcnt_r < CNT_W'(q_item.need_r))
              || ((rcnt_r + CNT_W'(q_item.room_r)) > CNT_W'(RETURN_DEPTH));

  assign clearing = (state_r == S_CLR);
  assign res      = '{status: run_r, depth: cnt_r, top: tos_r, pc: pc_r};

  // sequencer and datapath
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    ins_nxt   = ins_r;
    pc_nxt    = pc_r;
    tos_nxt   = tos_r;
    cnt_nxt   = cnt_r;
    rtop_nxt  = rtop_r;
    rcnt_nxt  = rcnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    run_nxt   = run_r;
    d_nxt     = d_r;
    m_nxt     = m_r;
    rr_nxt    = rr_r;
    wds_addr_nxt = wds_addr_r;
    wds_data_nxt = wds_data_r;
    wds_n_nxt    = wds_n_r;
    wm_addr_nxt  = wm_addr_r;
    wm_data_nxt  = wm_data_r;
    wm_n_nxt     = wm_n_r;
    q_pop     = 1'b0;
    res_valid = 1'b0;
    ds_we     = 1'b0;
    ds_waddr  = wds_addr_r[step_r];
    ds_wdata  = wds_data_r[step_r];
    rs_we     = 1'b0;
    rs_waddr  = rcnt_r[RS_AW-1:0];
    rs_wdata  = rtop_r;
    mem_we    = 1'b0;
    mem_waddr = wm_addr_r[step_r[0]];
    mem_wdata = wm_data_r[step_r[0]];

    case (state_r)
      // zero the data memory after reset
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + MEM_AW'(1);
        if (clr_r == MEM_AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take the next instruction and screen it
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          ins_nxt  = q_item;
          step_nxt = 2'd0;
          if (run_r != ST_RUN) begin
            state_nxt = S_OUT;
          end else if (q_item.bad) begin
            run_nxt   = ST_BADOP;
            state_nxt = S_OUT;
          end else if ((q_item.op == OP_RET) && (rcnt_r == '0)) begin
            run_nxt   = ST_HALT;
            state_nxt = S_OUT;
          end else if (fault) begin
            run_nxt   = ST_FAULT;
            state_nxt = S_OUT;
          end else if (q_item.nrd == 2'd0) begin
            state_nxt = S_EX;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      // one read per cycle, data lands in the next step
      S_RD, S_CAP: begin
        if (step_r != 2'd0) begin
          d_nxt[cap_ix] = ds_q;
          if (!cap_ix[1]) begin
            m_nxt[cap_ix[0]] = mem_q;
          end
          if (cap_ix == 2'd0) begin
            rr_nxt = rs_q;
          end
        end
        step_nxt = step_r + 2'd1;
        if (state_r == S_CAP) begin
          state_nxt = S_EX;
        end else if (step_r == ins_r.nrd - 2'd1) begin
          state_nxt = S_CAP;
        end
      end

      // compute new state and the write list
      S_EX: begin
        pc_nxt    = pc1;
        wds_n_nxt = 2'd0;
        wm_n_nxt  = 2'd0;
        case (ins_r.op)
          OP_ADD: begin tos_nxt = d_r[0] + tos_r; cnt_nxt = cm1; end
          OP_SUB: begin tos_nxt = d_r[0] - tos_r; cnt_nxt = cm1; end
          OP_LSL: begin
            tos_nxt = (|tos_r[WORD_BITS-1:6]) ? '0 : (d_r[0] << tos_r[5:0]);
            cnt_nxt = cm1;
          end
          OP_LSR: begin
            tos_nxt = (|tos_r[WORD_BITS-1:6]) ? '0 : (d_r[0] >> tos_r[5:0]);
            cnt_nxt = cm1;
          end
          OP_2SWAP: begin
            tos_nxt = d_r[1];
            wds_addr_nxt[0] = ix_m1; wds_data_nxt[0] = d_r[2];
            wds_addr_nxt[1] = ix_m2; wds_data_nxt[1] = tos_r;
            wds_addr_nxt[2] = ix_m3; wds_data_nxt[2] = d_r[0];
            wds_n_nxt = 2'd3;
          end
          OP_SWAP: begin
            tos_nxt = d_r[0];
            wds_addr_nxt[0] = ix_m1; wds_data_nxt[0] = tos_r;
            wds_n_nxt = 2'd1;
          end
          OP_DROP: begin tos_nxt = d_r[0]; cnt_nxt = cm1; end
          OP_2OVER: begin
            wds_addr_nxt[0] = ix_p0; wds_data_nxt[0] = tos_r;
            wds_addr_nxt[1] = ix_p1; wds_data_nxt[1] = d_r[2];
            wds_n_nxt = 2'd2;
            tos_nxt = d_r[1];
            cnt_nxt = cnt_r + CNT_W'(2);
          end
          OP_OVER: begin
            wds_addr_nxt[0] = ix_p0; wds_data_nxt[0] = tos_r;
            wds_n_nxt = 2'd1;
            tos_nxt = d_r[0];
            cnt_nxt = cp1;
          end
          OP_DUP: begin
            wds_addr_nxt[0] = ix_p0; wds_data_nxt[0] = tos_r;
            wds_n_nxt = 2'd1;
            cnt_nxt = cp1;
          end
          OP_ROT: begin
            wds_addr_nxt[0] = ix_m2; wds_data_nxt[0] = d_r[0];
            wds_addr_nxt[1] = ix_m1; wds_data_nxt[1] = tos_r;
            wds_n_nxt = 2'd2;
            tos_nxt = d_r[1];
          end
          OP_NROT: begin
            wds_addr_nxt[0] = ix_m1; wds_data_nxt[0] = d_r[1];
            wds_addr_nxt[1] = ix_m2; wds_data_nxt[1] = tos_r;
            wds_n_nxt = 2'd2;
            tos_nxt = d_r[0];
          end
          OP_TA: begin a_nxt = tos_r; tos_nxt = d_r[0]; cnt_nxt = cm1; end
          OP_TB: begin b_nxt = tos_r; tos_nxt = d_r[0]; cnt_nxt = cm1; end
          OP_FA, OP_FB, OP_ZERO, OP_IMM8, OP_IMMW: begin
            wds_addr_nxt[0] = ix_p0; wds_data_nxt[0] = tos_r;
            wds_n_nxt = 2'd1;
            cnt_nxt = cp1;
            case (ins_r.op)
              OP_FA:   tos_nxt = a_r;
              OP_FB:   tos_nxt = b_r;
              OP_ZERO: tos_nxt = '0;
              OP_IMM8: begin
                tos_nxt = {{(WORD_BITS-8){1'b0}}, ins_r.imm[7:0]};
                pc_nxt  = pc2;
              end
              default: begin
                tos_nxt = ins_r.imm;
                pc_nxt  = pc9;
              end
            endcase
          end
          OP_TR: begin
            rs_we    = 1'b1;
            rcnt_nxt = rcnt_r + CNT_W'(1);
            rtop_nxt = tos_r;
            tos_nxt  = d_r[0];
            cnt_nxt  = cm1;
          end
          OP_FR: begin
            wds_addr_nxt[0] = ix_p0; wds_data_nxt[0] = tos_r;
            wds_n_nxt = 2'd1;
            cnt_nxt  = cp1;
            tos_nxt  = rtop_r;
            rtop_nxt = rr_r;
            rcnt_nxt = rcm1;
          end
          OP_2LD: begin
            wds_addr_nxt[0] = ix_p0; wds_data_nxt[0] = m_r[1];
            wds_n_nxt = 2'd1;
            cnt_nxt = cp1;
            tos_nxt = m_r[0];
          end
          OP_LD:  tos_nxt = m_r[0];
          OP_BLD: tos_nxt = {{(WORD_BITS-8){1'b0}}, byte_sh[7:0]};
          OP_2ST: begin
            wm_addr_nxt[0] = mi + MEM_AW'(1); wm_data_nxt[0] = d_r[1];
            wm_addr_nxt[1] = mi;              wm_data_nxt[1] = d_r[0];
            wm_n_nxt = 2'd2;
            tos_nxt = d_r[2];
            cnt_nxt = cm3;
          end
          OP_ST: begin
            wm_addr_nxt[0] = mi; wm_data_nxt[0] = d_r[0];
            wm_n_nxt = 2'd1;
            tos_nxt = d_r[1];
            cnt_nxt = cm2;
          end
          OP_BST: begin
            wm_addr_nxt[0] = mi; wm_data_nxt[0] = merged;
            wm_n_nxt = 2'd1;
            tos_nxt = d_r[1];
            cnt_nxt = cm2;
          end
          OP_GT: begin tos_nxt = {WORD_BITS{d_r[0] > tos_r}};  cnt_nxt = cm1; end
          OP_LT: begin tos_nxt = {WORD_BITS{d_r[0] < tos_r}};  cnt_nxt = cm1; end
          OP_EQ: begin tos_nxt = {WORD_BITS{d_r[0] == tos_r}}; cnt_nxt = cm1; end
          OP_NE: begin tos_nxt = {WORD_BITS{d_r[0] != tos_r}}; cnt_nxt = cm1; end
          OP_AND: begin tos_nxt = tos_r & d_r[0]; cnt_nxt = cm1; end
          OP_OR:  begin tos_nxt = tos_r | d_r[0]; cnt_nxt = cm1; end
          OP_XOR: begin tos_nxt = tos_r ^ d_r[0]; cnt_nxt = cm1; end
          OP_NOT: tos_nxt = ~tos_r;
          OP_BGT: pc_nxt = (d_r[0] > tos_r) ? br : pc4;
          OP_BLT: pc_nxt = (d_r[0] < tos_r) ? br : pc4;
          OP_BZ: begin
            pc_nxt  = (tos_r == '0) ? br : pc4;
            tos_nxt = d_r[0];
            cnt_nxt = cm1;
          end
          OP_BNZ: begin
            pc_nxt  = (tos_r != '0) ? br : pc4;
            tos_nxt = d_r[0];
            cnt_nxt = cm1;
          end
          OP_B: pc_nxt = br;
          OP_BL: begin
            rs_we    = 1'b1;
            rcnt_nxt = rcnt_r + CNT_W'(1);
            rtop_nxt = WORD_BITS'(pc9);
            pc_nxt   = ins_r.imm[CODE_BITS-1:0];
          end
          OP_BNL: pc_nxt = ins_r.imm[CODE_BITS-1:0];
          OP_RET: begin
            pc_nxt   = rtop_r[CODE_BITS-1:0];
            rtop_nxt = rr_r;
            rcnt_nxt = rcm1;
          end
          default: pc_nxt = pc_r;
        endcase
        step_nxt = 2'd0;
        if ((wds_n_nxt != 2'd0) || (wm_n_nxt != 2'd0)) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_OUT;
        end
      end

      // write back, one entry per RAM per cycle
      S_WR: begin
        ds_we    = (step_r < wds_n_r);
        mem_we   = (step_r < wm_n_r);
        step_nxt = step_r + 2'd1;
        if ((step_nxt >= wds_n_r) && (step_nxt >= wm_n_r)) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // start address write also loads the program counter
    if (cfg_we) begin
      pc_nxt = cfg_value;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      step_r  <= 2'd0;
      clr_r   <= '0;
      pc_r    <= '0;
      tos_r   <= '0;
      cnt_r   <= '0;
      rtop_r  <= '0;
      rcnt_r  <= '0;
      a_r     <= '0;
      b_r     <= '0;
      run_r   <= ST_RUN;
      wds_n_r <= 2'd0;
      wm_n_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      tos_r   <= tos_nxt;
      cnt_r   <= cnt_nxt;
      rtop_r  <= rtop_nxt;
      rcnt_r  <= rcnt_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      run_r   <= run_nxt;
      wds_n_r <= wds_n_nxt;
      wm_n_r  <= wm_n_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    rr_r       <= rr_nxt;
    wds_addr_r <= wds_addr_nxt;
    wds_data_r <= wds_data_nxt;
    wm_addr_r  <= wm_addr_nxt;
    wm_data_r  <= wm_data_nxt;
  end

  fsc_ram #(.WIDTH(WORD_BITS), .DEPTH(DATA_DEPTH)) u_data_stack (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_q)
  );

  fsc_ram #(.WIDTH(WORD_BITS), .DEPTH(RETURN_DEPTH)) u_return_stack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_q)
  );

  fsc_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_data_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_q)
  );

endmodule
`default_nettype wire
